[rtl/assert_macros.svh]
// assertion macros used by the event queue top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WMEQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WMEQ_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) else $error(msg);
`else
`define WMEQ_ASSERT(label, clk, rst_n, prop, msg)
`define WMEQ_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

[rtl/wmeq_pkg.sv]
// types and codes shared by the event queue modules
package wmeq_pkg;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_FIND_FIRST = 3'd1,
    OP_FIND_LAST  = 3'd2,
    OP_REMOVE_POS = 3'd3,
    OP_REMOVE_ALL = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_MATCH  = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_POS_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  queue;
    logic [1:0]  etype;
    logic [31:0] play_from;
    logic [31:0] play_to;
    logic [31:0] buf_offset;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 128;

endpackage

[rtl/wmeq_cell.sv]
// one queue slot: holds an entry, takes its right neighbor or a loaded entry
module wmeq_cell (
  input  logic                clk_i,
  input  wmeq_pkg::cell_ctrl_t ctrl_i,
  input  wmeq_pkg::entry_t    load_i,
  input  wmeq_pkg::entry_t    right_i,
  output wmeq_pkg::entry_t    entry_o
);

  wmeq_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_i;
    end else if (ctrl_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[rtl/wildcard_match_event_queue.sv]
// event queue top: slot chain, scan sequencer and output register
// append and rejected requests go from accept to the emit state; search and remove
// requests pass first through the scan: the chain rotates one slot past the head
//   per cycle over every live entry, matching and compacting as it goes
// the result goes to the output register when free; only then is a request taken
// reset empties the queue and clears the id counter; slot contents are not cleared
`include "assert_macros.svh"
module wildcard_match_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // event_queue, event_type, play_from, play_to, buf_offset, position
  input  logic [wmeq_pkg::InDataW-1:0]    s_axis_tdata,
  // operation
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // found_position, found_id, found_queue, found_type, found_play_from,
  // found_play_to, found_buf_offset, fill_level, zero pad
  output logic [wmeq_pkg::OutDataW-1:0]   m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  wmeq_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  occ_q, occ_d;
  logic [15:0]       next_id_q, next_id_d;
  wmeq_pkg::op_e     op_q, op_d;
  logic [1:0]        req_queue_q, req_queue_d;
  logic [1:0]        req_type_q, req_type_d;
  logic [3:0]        pos_q, pos_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              hit_q, hit_d;
  wmeq_pkg::status_e res_status_q, res_status_d;
  logic [3:0]        res_pos_q, res_pos_d;
  wmeq_pkg::entry_t  res_entry_q, res_entry_d;

  logic              out_valid_q;
  wmeq_pkg::status_e out_status_q;
  logic [3:0]        out_pos_q;
  wmeq_pkg::entry_t  out_entry_q;
  logic [4:0]        out_fill_q;

  logic              accept;
  logic              start_scan;
  logic              append_load;
  logic              scan_step;
  logic              scan_keep;
  logic              emit;
  logic              head_match;
  logic              rm_now;
  logic              cap_now;
  wmeq_pkg::op_e     in_op;
  wmeq_pkg::entry_t  in_entry;
  wmeq_pkg::entry_t  load_entry;
  wmeq_pkg::entry_t  head;
  wmeq_pkg::entry_t  cell_out [QUEUE_DEPTH];
  wmeq_pkg::cell_ctrl_t cell_ctrl [QUEUE_DEPTH];

  // input beat unpacking
  assign in_op                 = wmeq_pkg::op_e'(s_axis_tuser);
  assign in_entry.queue        = s_axis_tdata[1:0];
  assign in_entry.etype        = s_axis_tdata[3:2];
  assign in_entry.play_from    = s_axis_tdata[35:4];
  assign in_entry.play_to      = s_axis_tdata[67:36];
  assign in_entry.buf_offset   = s_axis_tdata[99:68];
  assign in_entry.id           = next_id_q;

  assign s_axis_tready = (state_q == wmeq_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // slot chain, head at cell 0
  assign head       = cell_out[0];
  assign load_entry = (state_q == wmeq_pkg::S_IDLE) ? in_entry : head;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    wmeq_pkg::entry_t right;
    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_out[k];
    end else begin : g_mid
      assign right = cell_out[k+1];
    end
    // kept head goes back in at the current live tail
    assign cell_ctrl[k].shift = scan_step;
    assign cell_ctrl[k].load  = (append_load && occ_q == CNT_W'(k)) ||
                                (scan_step && scan_keep && occ_q == CNT_W'(k + 1));
    wmeq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[k]),
      .load_i  (load_entry),
      .right_i (right),
      .entry_o (cell_out[k])
    );
  end

  assign head_match = (req_queue_q == 2'd0 || head.queue == req_queue_q) &&
                      (req_type_q == 2'd0 || head.etype == req_type_q);

  always_comb begin
    rm_now  = 1'b0;
    cap_now = 1'b0;
    case (op_q)
      wmeq_pkg::OP_FIND_FIRST: cap_now = head_match && !hit_q;
      wmeq_pkg::OP_FIND_LAST:  cap_now = head_match;
      wmeq_pkg::OP_REMOVE_POS: begin
        rm_now  = (32'(idx_q) == 32'(pos_q));
        cap_now = rm_now;
      end
      wmeq_pkg::OP_REMOVE_ALL: begin
        rm_now  = head_match;
        cap_now = head_match && !hit_q;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wmeq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = start_scan ? wmeq_pkg::S_SCAN : wmeq_pkg::S_EMIT;
        end
      end
      wmeq_pkg::S_SCAN: begin
        if (left_q == CNT_W'(1)) begin
          state_d = wmeq_pkg::S_EMIT;
        end
      end
      wmeq_pkg::S_EMIT: begin
        if (emit) begin
          state_d = wmeq_pkg::S_IDLE;
        end
      end
      default: state_d = wmeq_pkg::S_IDLE;
    endcase
  end

  // datapath control per state
  always_comb begin
    occ_d        = occ_q;
    next_id_d    = next_id_q;
    op_d         = op_q;
    req_queue_d  = req_queue_q;
    req_type_d   = req_type_q;
    pos_d        = pos_q;
    idx_d        = idx_q;
    left_d       = left_q;
    hit_d        = hit_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_entry_d  = res_entry_q;
    start_scan   = 1'b0;
    append_load  = 1'b0;
    scan_step    = 1'b0;
    scan_keep    = 1'b0;
    emit         = 1'b0;
    case (state_q)
      wmeq_pkg::S_IDLE: begin
        if (accept) begin
          op_d         = in_op;
          req_queue_d  = in_entry.queue;
          req_type_d   = in_entry.etype;
          pos_d        = s_axis_tdata[103:100];
          idx_d        = '0;
          left_d       = occ_q;
          hit_d        = 1'b0;
          res_status_d = wmeq_pkg::STAT_NO_MATCH;
          case (in_op)
            wmeq_pkg::OP_APPEND: begin
              if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
                res_status_d = wmeq_pkg::STAT_FULL;
              end else begin
                append_load  = 1'b1;
                occ_d        = occ_q + 1'b1;
                next_id_d    = next_id_q + 16'd1;
                res_status_d = wmeq_pkg::STAT_DONE;
                res_pos_d    = 4'(occ_q);
                res_entry_d  = in_entry;
              end
            end
            wmeq_pkg::OP_FIND_FIRST, wmeq_pkg::OP_FIND_LAST,
            wmeq_pkg::OP_REMOVE_ALL: begin
              start_scan = (occ_q != '0);
            end
            wmeq_pkg::OP_REMOVE_POS: begin
              if (32'(s_axis_tdata[103:100]) < 32'(occ_q)) begin
                start_scan = 1'b1;
              end else begin
                res_status_d = wmeq_pkg::STAT_POS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      wmeq_pkg::S_SCAN: begin
        scan_step = 1'b1;
        scan_keep = !rm_now;
        if (rm_now) begin
          occ_d = occ_q - 1'b1;
        end
        if (cap_now) begin
          hit_d        = 1'b1;
          res_status_d = wmeq_pkg::STAT_DONE;
          res_pos_d    = 4'(idx_q);
          res_entry_d  = head;
        end
        idx_d  = idx_q + 1'b1;
        left_d = left_q - 1'b1;
      end
      wmeq_pkg::S_EMIT: begin
        emit = !out_valid_q || m_axis_tready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wmeq_pkg::S_IDLE;
      occ_q     <= '0;
      next_id_q <= '0;
      left_q    <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      next_id_q <= next_id_d;
      left_q    <= left_d;
      hit_q     <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_queue_q  <= req_queue_d;
    req_type_q   <= req_type_d;
    pos_q        <= pos_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_entry_q  <= res_entry_d;
  end

  // output register, holds the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= res_status_q;
      out_fill_q   <= 5'(occ_q);
      if (res_status_q == wmeq_pkg::STAT_DONE) begin
        out_pos_q   <= res_pos_q;
        out_entry_q <= res_entry_q;
      end else begin
        out_pos_q   <= '0;
        out_entry_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_fill_q, out_entry_q.buf_offset,
                          out_entry_q.play_to, out_entry_q.play_from,
                          out_entry_q.etype, out_entry_q.queue, out_entry_q.id, out_pos_q};

  `WMEQ_ASSERT_NEVER(a_occ_bound, clk_i, rst_ni, 32'(occ_q) > QUEUE_DEPTH, "occupancy above depth")
  `WMEQ_ASSERT(a_append_grows, clk_i, rst_ni, append_load |=> occ_q == $past(occ_q) + 1'b1, "append lost")
  `WMEQ_ASSERT(a_scan_shrinks, clk_i, rst_ni, scan_step |=> occ_q <= $past(occ_q), "scan grew queue")
  `WMEQ_ASSERT(a_scan_live, clk_i, rst_ni, (state_q == wmeq_pkg::S_SCAN) |-> (left_q != '0), "empty scan")

endmodule
